// ===== rtl/srtg_pkg.sv =====
// Package for the shift register tone generator.
// Holds the command codes, register indexes, level constants and the result type.
// No dependencies; the other files refer to it by scoped names, and the checker imports it.
package srtg_pkg;

    // Item commands.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Register indexes that the logic looks at.
    localparam logic [3:0] REG_PERIOD_LO = 4'd8;
    localparam logic [3:0] REG_PERIOD_HI = 4'd9;
    localparam logic [3:0] REG_PATTERN   = 4'd10;
    localparam logic [3:0] REG_MODE      = 4'd11;
    localparam logic [3:0] REG_CONTROL   = 4'd12;

    // Mode field value that selects hardware mode.
    localparam logic [2:0] MODE_HARDWARE = 3'd4;

    // Widths and level constants.
    localparam int COUNT_W  = 18;
    localparam int SAMPLE_W = 15;
    localparam logic [SAMPLE_W-1:0] LEVEL_HIGH = 15'd32767;
    localparam logic [7:0] CTRL_HIGH = 8'he0;
    localparam logic [7:0] CTRL_LOW  = 8'hc0;
    localparam logic [COUNT_W-1:0] TICK_DROP = 18'd4;
    localparam logic [COUNT_W-1:0] HW_START  = 18'd2;

    // One result item.
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [7:0]          control_mirror;
    } result_t;

endpackage

// ===== rtl/srtg_core.sv =====
// Tone generator state: pattern, period counter, level and the registers that matter.
// Computes each item's result in one pass and updates state on acceptance.
// Depends on srtg_pkg.
module srtg_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic                 enable,
    input  logic                 cmd,
    input  logic [3:0]           reg_addr,
    input  logic [7:0]           write_data,
    output srtg_pkg::result_t    result
);

    logic [7:0]                   period_lo_reg, period_lo_next;
    logic [7:0]                   period_hi_reg, period_hi_next;
    logic [7:0]                   mode_reg, mode_next;
    logic [7:0]                   control_reg, control_next;
    logic [7:0]                   pattern_reg, pattern_next;
    logic [7:0]                   saved_reg, saved_next;
    logic [srtg_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                         level_reg, level_next;

    logic                         hw_mode;
    logic [srtg_pkg::COUNT_W-1:0] reload_add;

    // Hardware mode is taken from the mode register before this item.
    assign hw_mode = (mode_reg[4:2] == srtg_pkg::MODE_HARDWARE);

    // Counter increment on a reload: reload minus the tick drop.
    always_comb begin
        reload_add = {{(srtg_pkg::COUNT_W-9){1'b0}}, period_lo_reg, 1'b0};
        if (!hw_mode) begin
            reload_add = reload_add
                + {{(srtg_pkg::COUNT_W-17){1'b0}}, period_hi_reg, 9'd0};
        end
    end

    // Next state for a register write or a sample tick.
    always_comb begin
        period_lo_next = period_lo_reg;
        period_hi_next = period_hi_reg;
        mode_next      = mode_reg;
        control_next   = control_reg;
        pattern_next   = pattern_reg;
        saved_next     = saved_reg;
        count_next     = count_reg;
        level_next     = level_reg;
        case (cmd)
            srtg_pkg::CMD_WRITE: begin
                case (reg_addr)
                    srtg_pkg::REG_PERIOD_LO: period_lo_next = write_data;
                    srtg_pkg::REG_PERIOD_HI: begin
                        period_hi_next = write_data;
                        if ((period_hi_reg == 8'd0) != (write_data == 8'd0)) begin
                            pattern_next = saved_reg;
                        end
                    end
                    srtg_pkg::REG_PATTERN: begin
                        pattern_next = write_data;
                        saved_next   = write_data;
                        if (hw_mode) begin
                            count_next = srtg_pkg::HW_START;
                        end
                    end
                    srtg_pkg::REG_MODE:    mode_next = write_data;
                    srtg_pkg::REG_CONTROL: control_next = write_data;
                    default: ;
                endcase
            end
            default: begin
                if (enable) begin
                    if (count_reg < srtg_pkg::TICK_DROP) begin
                        level_next   = pattern_reg[0];
                        pattern_next = {pattern_reg[0], pattern_reg[7:1]};
                        count_next   = count_reg + reload_add;
                    end else begin
                        count_next = count_reg - srtg_pkg::TICK_DROP;
                    end
                    if (!hw_mode) begin
                        control_next = level_next ? srtg_pkg::CTRL_HIGH
                                                  : srtg_pkg::CTRL_LOW;
                    end
                end else begin
                    level_next = 1'b0;
                end
            end
        endcase
    end

    // Result reflects the state after the item.
    assign result.sample         = level_next ? srtg_pkg::LEVEL_HIGH : '0;
    assign result.control_mirror = control_next;

    // State update on each accepted request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_lo_reg <= '0;
            period_hi_reg <= '0;
            mode_reg      <= '0;
            control_reg   <= '0;
            pattern_reg   <= '0;
            saved_reg     <= '0;
            count_reg     <= '0;
            level_reg     <= 1'b0;
        end else if (accept) begin
            period_lo_reg <= period_lo_next;
            period_hi_reg <= period_hi_next;
            mode_reg      <= mode_next;
            control_reg   <= control_next;
            pattern_reg   <= pattern_next;
            saved_reg     <= saved_next;
            count_reg     <= count_next;
            level_reg     <= level_next;
        end
    end

endmodule

// ===== rtl/srtg_out_buf.sv =====
// Result register with a skid entry for the tone generator output channel.
// Lets a new request in while a finished result still waits.
// Depends on srtg_pkg.
module srtg_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  srtg_pkg::result_t push_data,
    output logic              push_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output srtg_pkg::result_t out_data
);

    logic              main_valid_reg;
    logic              skid_valid_reg;
    srtg_pkg::result_t main_reg;
    srtg_pkg::result_t skid_reg;
    logic              pop;

    assign pop        = main_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_data   = main_reg;

    // Valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= push;
            end
        end else if (push) begin
            if (main_valid_reg) begin
                skid_valid_reg <= 1'b1;
            end else begin
                main_valid_reg <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (pop) begin
            if (skid_valid_reg) begin
                main_reg <= skid_reg;
            end else if (push) begin
                main_reg <= push_data;
            end
        end else if (push) begin
            if (main_valid_reg) begin
                skid_reg <= push_data;
            end else begin
                main_reg <= push_data;
            end
        end
    end

endmodule

// ===== rtl/shift_register_tone_generator.sv =====
// Shift register tone generator: square-pattern tone from a rotating 8-bit pattern.
// Each accepted request's result is registered in the output buffer.
// Throughput: one request per cycle while the output is taken; a two-entry output buffer absorbs one stall.
// Reset (aresetn low, synchronous): registers, pattern, counter, level and enable clear.
// Depends on srtg_pkg, srtg_core and srtg_out_buf.
module shift_register_tone_generator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_cmd,
    input  logic [3:0]                    s_reg_addr,
    input  logic [7:0]                    s_write_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [srtg_pkg::SAMPLE_W-1:0] m_sample,
    output logic [7:0]                    m_control_mirror
);

    logic              enable_reg;
    logic              accept;
    srtg_pkg::result_t core_result;
    srtg_pkg::result_t out_result;

    // Channel enable register; writes are always taken.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
        end else if (cfg_valid) begin
            enable_reg <= cfg_data;
        end
    end

    assign accept = s_valid && s_ready;

    srtg_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .enable     (enable_reg),
        .cmd        (s_cmd),
        .reg_addr   (s_reg_addr),
        .write_data (s_write_data),
        .result     (core_result)
    );

    srtg_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (accept),
        .push_data  (core_result),
        .push_ready (s_ready),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_data   (out_result)
    );

    assign m_sample         = out_result.sample;
    assign m_control_mirror = out_result.control_mirror;

    // An accepted request always leaves a result waiting on the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted request produced no result");

    // A stalled output with a full buffer must block new requests.
    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && m_valid && !m_ready) |=> !s_ready)
        else $error("output buffer overfilled");

    // A tick while disabled gives silence when it reaches the output at once.
    a_disabled_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_cmd == srtg_pkg::CMD_TICK && !enable_reg && (!m_valid || m_ready))
        |=> (m_sample == '0))
        else $error("disabled tick produced sound");

    // The sample is always one of the two levels.
    a_two_levels: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_sample == '0 || m_sample == srtg_pkg::LEVEL_HIGH))
        else $error("sample out of level set");

endmodule

// ===== verif/srtg_tone_checker.sv =====
// Checker for the shift register tone generator: watches the config, request and result channels.
// Predicts each result from its own copy of the register file, pattern and counter, then compares.
// Depends on srtg_pkg for the command codes, register indexes, level constants and result_t.
module srtg_tone_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic                          cfg_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_cmd,
    input  logic [3:0]                    s_reg_addr,
    input  logic [7:0]                    s_write_data,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [srtg_pkg::SAMPLE_W-1:0] m_sample,
    input  logic [7:0]                    m_control_mirror,
    output int                            mismatches,
    output int                            outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import srtg_pkg::*;

    // Fixed part of the reload: reg8 * 2 plus this.
    localparam logic [COUNT_W-1:0] RELOAD_BASE = 18'd4;

    // Predicted block state.
    logic [7:0]         tone_regs [16];
    logic [7:0]         tone_pattern;
    logic [7:0]         tone_saved;
    logic [COUNT_W-1:0] tone_count;
    logic               tone_level;
    logic               tone_enable;

    // Results predicted but not yet seen on the result channel, oldest first.
    result_t expected_tones [$];

    // Prints one line for a mismatch and counts it.
    task automatic flag_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatches = mismatches + 1;
    endtask

    // Applies one request to the predicted state and returns the result it causes.
    function automatic result_t advance_tone(input logic cmd, input logic [3:0] addr,
                                             input logic [7:0] data);
        result_t            res;
        logic               hw;
        logic [COUNT_W-1:0] reload;
        hw = (tone_regs[REG_MODE][4:2] == MODE_HARDWARE);
        if (cmd == CMD_WRITE) begin
            if (addr == REG_PERIOD_HI) begin
                // A zero/nonzero change of the high period byte restarts the pattern.
                if ((tone_regs[REG_PERIOD_HI] == 8'd0) != (data == 8'd0)) begin
                    tone_pattern = tone_saved;
                end
            end else if (addr == REG_PATTERN) begin
                tone_pattern = data;
                tone_saved   = data;
                if (hw) begin
                    tone_count = HW_START;
                end
            end
            tone_regs[addr] = data;
        end else if (tone_enable) begin
            reload = {9'd0, tone_regs[REG_PERIOD_LO], 1'b0} + RELOAD_BASE;
            if (!hw) begin
                reload = reload + {1'b0, tone_regs[REG_PERIOD_HI], 9'd0};
            end
            // Below the drop the pattern steps and the counter reloads.
            if (tone_count < TICK_DROP) begin
                tone_level   = tone_pattern[0];
                tone_pattern = {tone_pattern[0], tone_pattern[7:1]};
                tone_count   = tone_count + reload - TICK_DROP;
            end else begin
                tone_count = tone_count - TICK_DROP;
            end
            if (!hw) begin
                tone_regs[REG_CONTROL] = tone_level ? CTRL_HIGH : CTRL_LOW;
            end
        end else begin
            tone_level = 1'b0;
        end
        res.sample         = tone_level ? LEVEL_HIGH : '0;
        res.control_mirror = tone_regs[REG_CONTROL];
        return res;
    endfunction

    // Compare accepted results first, then predict accepted requests and track the enable.
    always @(posedge aclk) begin : watch
        result_t want;
        int      idx;
        if (!aresetn) begin
            for (idx = 0; idx < 16; idx++) begin
                tone_regs[idx] = 8'd0;
            end
            tone_pattern = 8'd0;
            tone_saved   = 8'd0;
            tone_count   = '0;
            tone_level   = 1'b0;
            tone_enable  = 1'b0;
            expected_tones.delete();
            mismatches   = 0;
            outstanding <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_tones.size() == 0) begin
                    flag_mismatch($sformatf("result with no request pending: sample %0d control %02h",
                                            m_sample, m_control_mirror));
                end else begin
                    want = expected_tones.pop_front();
                    if (m_sample !== want.sample) begin
                        flag_mismatch($sformatf("sample %0d, expected %0d",
                                                m_sample, want.sample));
                    end
                    if (m_control_mirror !== want.control_mirror) begin
                        flag_mismatch($sformatf("control_mirror %02h, expected %02h",
                                                m_control_mirror, want.control_mirror));
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_tones.push_back(advance_tone(s_cmd, s_reg_addr, s_write_data));
            end
            if (cfg_valid && cfg_ready) begin
                tone_enable = cfg_data;
            end
            outstanding <= expected_tones.size();
        end
    end

endmodule

// ===== verif/tb_shift_register_tone_generator.sv =====
// Testbench top for the shift register tone generator: clock, reset, requests, stalls, verdict.
// Directed requests first, then random phases with the channel enabled and disabled.
// Depends on srtg_pkg, the block itself and srtg_tone_checker, which does all result checking.
module tb_shift_register_tone_generator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         MAX_IDLE     = 16;
    localparam int         DRAIN_CYCLES = 16;
    localparam int         STALL_LIMIT  = 2000;
    localparam logic [3:0] REG_FIRST    = 4'd0;
    localparam logic [3:0] REG_LAST     = 4'd15;

    logic                          aclk;
    logic                          aresetn      = 1'b0;
    logic                          cfg_valid    = 1'b0;
    logic                          cfg_data     = 1'b0;
    logic                          s_valid      = 1'b0;
    logic                          s_cmd        = srtg_pkg::CMD_WRITE;
    logic [3:0]                    s_reg_addr   = 4'd0;
    logic [7:0]                    s_write_data = 8'd0;
    logic                          m_ready      = 1'b0;
    logic                          cfg_ready;
    logic                          s_ready;
    logic                          m_valid;
    logic [srtg_pkg::SAMPLE_W-1:0] m_sample;
    logic [7:0]                    m_control_mirror;

    int   mismatches;
    int   outstanding;
    int   stall_cycles = 0;
    int   rx_wait      = 0;
    // While set, neither side idles.
    logic calm         = 1'b0;

    // 12 ns clock.
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    shift_register_tone_generator dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_reg_addr       (s_reg_addr),
        .s_write_data     (s_write_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_sample         (m_sample),
        .m_control_mirror (m_control_mirror)
    );

    srtg_tone_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_reg_addr       (s_reg_addr),
        .s_write_data     (s_write_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_sample         (m_sample),
        .m_control_mirror (m_control_mirror),
        .mismatches       (mismatches),
        .outstanding      (outstanding)
    );

    // Result side: after each accepted result, hold ready low for a random pause, which may be empty.
    always @(posedge aclk) begin : receiver
        int unsigned pause;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            m_ready <= (rx_wait == 1);
        end else if (m_valid && m_ready) begin
            pause   = calm ? 0 : $urandom_range(0, MAX_IDLE);
            rx_wait <= int'(pause);
            m_ready <= (pause == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: ends the run when no channel has moved anything for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_shift_register_tone_generator failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Presents one request after a random gap and waits for it to be accepted.
    task automatic send_request(input logic cmd, input logic [3:0] addr, input logic [7:0] data);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_reg_addr   <= addr;
        s_write_data <= data;
        do @(posedge aclk); while (!s_ready);
        if ($urandom_range(0, 39) == 0) begin
            calm <= !calm;
        end
    endtask

    // A tick ignores the address and data, so those carry noise.
    task automatic send_tick();
        send_request(srtg_pkg::CMD_TICK, 4'($urandom_range(0, 15)),
                     8'($urandom_range(0, 255)));
    endtask

    // Drops valid and waits until every predicted result has come out.
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic set_enable(input logic value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Mostly ticks; writes lean on the registers the tone logic uses, with short periods.
    task automatic random_request();
        logic [3:0] addr;
        logic [7:0] data;
        if ($urandom_range(0, 99) < 70) begin
            send_tick();
        end else begin
            case ($urandom_range(0, 5))
                0:       addr = srtg_pkg::REG_PERIOD_LO;
                1:       addr = srtg_pkg::REG_PERIOD_HI;
                2:       addr = srtg_pkg::REG_PATTERN;
                3:       addr = srtg_pkg::REG_MODE;
                4:       addr = srtg_pkg::REG_CONTROL;
                default: addr = 4'($urandom_range(0, 15));
            endcase
            data = 8'($urandom_range(0, 255));
            if (addr == srtg_pkg::REG_PERIOD_LO) begin
                if ($urandom_range(0, 9) < 7) begin
                    data = 8'($urandom_range(0, 7));
                end
            end else if (addr == srtg_pkg::REG_PERIOD_HI) begin
                case ($urandom_range(0, 19))
                    0:              data = 8'($urandom_range(0, 255));
                    1, 2, 3:        data = 8'($urandom_range(1, 3));
                    default:        data = 8'd0;
                endcase
            end else if (addr == srtg_pkg::REG_MODE) begin
                if ($urandom_range(0, 1) == 0) begin
                    data = (data & 8'he3) | {3'd0, srtg_pkg::MODE_HARDWARE, 2'd0};
                end
            end
            send_request(srtg_pkg::CMD_WRITE, addr, data);
        end
    endtask

    // One random phase at a given enable setting, started from idle.
    task automatic run_phase(input logic enable, input int count);
        wait_idle();
        set_enable(enable);
        repeat (count) random_request();
    endtask

    // Stimulus and verdict.
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Disabled out of reset: silence.
        send_tick();
        wait_idle();
        set_enable(1'b1);

        // Software mode, empty pattern, then a pattern with the shortest period.
        send_tick();
        send_request(srtg_pkg::CMD_WRITE, srtg_pkg::REG_PATTERN, 8'ha5);
        send_request(srtg_pkg::CMD_WRITE, srtg_pkg::REG_PERIOD_LO, 8'h00);
        send_request(srtg_pkg::CMD_WRITE, srtg_pkg::REG_PERIOD_HI, 8'h00);
        send_tick();
        send_tick();
        send_tick();
        // High period byte: zero to nonzero, nonzero to nonzero, back to zero.
        send_request(srtg_pkg::CMD_WRITE, srtg_pkg::REG_PERIOD_HI, 8'h01);
        send_tick();
        send_request(srtg_pkg::CMD_WRITE, srtg_pkg::REG_PERIOD_HI, 8'hff);
        send_request(srtg_pkg::CMD_WRITE, srtg_pkg::REG_PERIOD_HI, 8'h00);
        send_tick();
        // Longest low period byte.
        send_request(srtg_pkg::CMD_WRITE, srtg_pkg::REG_PERIOD_LO, 8'hff);
        send_tick();
        // Hardware mode: a pattern write restarts the counter.
        send_request(srtg_pkg::CMD_WRITE, srtg_pkg::REG_MODE,
                     {3'd0, srtg_pkg::MODE_HARDWARE, 2'd0});
        send_request(srtg_pkg::CMD_WRITE, srtg_pkg::REG_PATTERN, 8'h01);
        send_tick();
        send_request(srtg_pkg::CMD_WRITE, srtg_pkg::REG_PERIOD_LO, 8'h00);
        send_request(srtg_pkg::CMD_WRITE, srtg_pkg::REG_PATTERN, 8'h81);
        send_tick();
        // Direct control write holds in hardware mode.
        send_request(srtg_pkg::CMD_WRITE, srtg_pkg::REG_CONTROL, 8'hff);
        send_tick();
        // Leave hardware mode; touch the lowest and highest registers.
        send_request(srtg_pkg::CMD_WRITE, srtg_pkg::REG_MODE, 8'hef);
        send_request(srtg_pkg::CMD_WRITE, REG_FIRST, 8'hff);
        send_request(srtg_pkg::CMD_WRITE, REG_LAST, 8'h00);
        send_tick();

        run_phase(1'b1, 700);
        run_phase(1'b0, 200);
        run_phase(1'b1, 700);
        run_phase(1'b0, 100);
        run_phase(1'b1, 250);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_shift_register_tone_generator passed");
        end else begin
            $display("tb_shift_register_tone_generator failed");
        end
        $finish;
    end

endmodule
